// ----- rtl/core/fwbt_pkg.sv -----
package fwbt_pkg;

    localparam int WAYS      = 4;
    localparam int AGE_W     = 8;
    localparam int FLAGS_W   = 5;
    localparam int DEPTH_W   = 8;
    localparam int MOVE_W    = 15;
    localparam int SCORE_W   = 16;
    localparam int TAG_W     = 32;
    localparam int KEY_W     = 64;
    localparam int REC_W     = MOVE_W + SCORE_W + DEPTH_W;
    localparam int IDX_W     = 5;
    localparam int WAY_W     = 2;
    localparam int RSCORE_W  = AGE_W + DEPTH_W;

    localparam logic [IDX_W-1:0] IDX_RESET = 5'd16;
    localparam logic [IDX_W-1:0] IDX_MIN   = 5'd2;
    localparam logic [IDX_W-1:0] IDX_MAX   = 5'd16;

    // entry age after reset or clear, and xor mask for a wiped duplicate
    localparam logic [AGE_W-1:0] AGE_HALF  = 8'h80;

    localparam logic [2:0] CMD_LOWER     = 3'd0;
    localparam logic [2:0] CMD_LOWER_ALL = 3'd1;
    localparam logic [2:0] CMD_UPPER     = 3'd2;
    localparam logic [2:0] CMD_UPPER_CUT = 3'd3;
    localparam logic [2:0] CMD_EXACT     = 3'd4;
    localparam logic [2:0] CMD_AGE_TICK  = 3'd5;
    localparam logic [2:0] CMD_CLEAR     = 3'd6;

    localparam int FL_LOWER = 0;
    localparam int FL_UPPER = 1;
    localparam int FL_ALL   = 2;
    localparam int FL_CUT   = 3;
    localparam int FL_EXACT = 4;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [KEY_W-1:0]         key;
        logic [MOVE_W-1:0]        move_code;
        logic [DEPTH_W-1:0]       search_depth;
        logic signed [SCORE_W-1:0] score;
        logic [FLAGS_W-1:0]       exact_flags;
    } t_in_item;

    typedef struct packed {
        logic             matched;
        logic [WAY_W-1:0] way;
        logic             done_res;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [MOVE_W-1:0]  mv;
        logic [DEPTH_W-1:0] ldep;
        logic [DEPTH_W-1:0] udep;
        logic [SCORE_W-1:0] lval;
        logic [SCORE_W-1:0] uval;
        logic [AGE_W-1:0]   age;
        logic [FLAGS_W-1:0] flags;
    } t_ent_way;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;   // depth, score, move from msb down
        logic [AGE_W-1:0] age;
    } t_pv_way;

    typedef t_ent_way [WAYS-1:0] t_ent_row;
    typedef t_pv_way  [WAYS-1:0] t_pv_row;

    typedef struct packed {
        logic load;
        logic rd;
        logic score;
        logic wr;
        logic tick;
        logic clr_start;
        logic clr_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

// ----- rtl/core/fwbt_ctrl.sv -----
module fwbt_ctrl import fwbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_SCORE = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_cmd, n_clr_cmd;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_clr_cmd   = r_clr_cmd;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_cmd inside {[CMD_LOWER:CMD_EXACT]}) begin
                        n_state = S_READ;
                    end else if (i_in_cmd == CMD_AGE_TICK) begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_DONE;
                    end else if (i_in_cmd == CMD_CLEAR) begin
                        o_cmd.clr_start = 1'b1;
                        n_clr_cmd       = 1'b1;
                        n_state         = S_CLEAR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SCORE;
            end
            S_SCORE: begin
                o_cmd.score = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_clr_cmd      = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/fwbt_datapath.sv -----
module fwbt_datapath import fwbt_pkg::*; #(
    parameter int TABLE_ENTRIES = 65536,
    parameter int PV_ENTRIES    = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  t_in_item         i_item,
    input  logic [IDX_W-1:0] i_index_bits,
    output t_out_item        o_item
);

    localparam int EROWS = TABLE_ENTRIES / WAYS;
    localparam int PROWS = PV_ENTRIES / WAYS;
    localparam int ERA   = $clog2(EROWS);
    localparam int PRA   = $clog2(PROWS);
    localparam int MROWS = (EROWS > PROWS) ? EROWS : PROWS;
    localparam int CW    = $clog2(MROWS);

    t_ent_row ent_mem [EROWS];
    t_pv_row  pv_mem  [PROWS];

    t_in_item          r_item;
    logic [AGE_W-1:0]  r_age;
    logic [CW-1:0]     r_cnt;
    t_ent_row          r_ent;
    t_pv_row           r_pv;
    logic              r_hit_any;
    logic [WAY_W-1:0]  r_hit_way;
    logic [WAYS-1:0]   r_wipe;
    logic [WAY_W-1:0]  r_best;
    logic              r_pv_hit;
    logic [WAY_W-1:0]  r_pv_way;
    logic [WAY_W-1:0]  r_pv_best;
    logic              r_res_matched;
    logic [WAY_W-1:0]  r_res_way;
    t_out_item         r_out;

    logic [IDX_W-1:0]  bits_c;
    logic [ERA-1:0]    erow;
    logic [PRA-1:0]    prow;

    // bucket row: key bits [bits-1:2]
    always_comb begin
        bits_c = (i_index_bits < IDX_MIN) ? IDX_MIN :
                 ((i_index_bits > IDX_MAX) ? IDX_MAX : i_index_bits);
        for (int r = 0; r < ERA; r++) begin
            erow[r] = ((r + 2) < int'(bits_c)) ? r_item.key[r+2] : 1'b0;
        end
    end
    assign prow = r_item.key[PRA+1:2];

    // scoring of the four ways read
    logic [WAYS-1:0]     hit;
    logic [WAYS-1:0]     wipe;
    logic                hit_any;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    best_way;
    logic                pv_hit;
    logic [WAY_W-1:0]    pv_hw;
    logic [WAY_W-1:0]    pv_best;

    always_comb begin
        logic [DEPTH_W-1:0]  md;
        logic                tagm;
        logic [RSCORE_W-1:0] sc, bsc, psc, pbsc;
        logic [DEPTH_W-1:0]  dep;
        dep      = r_item.search_depth;
        hit      = '0;
        wipe     = '0;
        hit_any  = 1'b0;
        hit_way  = '0;
        best_way = '0;
        bsc      = '0;
        pv_hit   = 1'b0;
        pv_hw    = '0;
        pv_best  = '0;
        pbsc     = '0;
        for (int i = 0; i < WAYS; i++) begin
            md   = (r_ent[i].ldep > r_ent[i].udep) ? r_ent[i].ldep : r_ent[i].udep;
            tagm = (r_ent[i].tag == r_item.key[KEY_W-1:KEY_W-TAG_W]);
            case (r_item.cmd)
                CMD_LOWER:     hit[i] = tagm && !r_ent[i].flags[FL_EXACT]
                                        && (r_ent[i].ldep <= dep);
                CMD_LOWER_ALL: hit[i] = tagm && ((r_ent[i].ldep == '0)
                                        || r_ent[i].flags[FL_ALL]) && (r_ent[i].ldep <= dep);
                CMD_UPPER:     hit[i] = tagm && !r_ent[i].flags[FL_EXACT]
                                        && (r_ent[i].udep <= dep);
                CMD_UPPER_CUT: hit[i] = tagm && ((r_ent[i].udep == '0)
                                        || r_ent[i].flags[FL_CUT]) && (r_ent[i].udep <= dep);
                default:       hit[i] = tagm && (md <= dep);
            endcase
            // later duplicates of an exact hit are wiped
            wipe[i] = hit[i] && hit_any && (r_item.cmd == CMD_EXACT);
            if (hit[i] && !hit_any) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(i);
            end
            sc = {r_age - r_ent[i].age, 8'hff - md};
            if (sc > bsc) begin
                bsc      = sc;
                best_way = WAY_W'(i);
            end
            if ((r_pv[i].key == r_item.key) && !pv_hit) begin
                pv_hit = 1'b1;
                pv_hw  = WAY_W'(i);
            end
            psc = {r_age - r_pv[i].age, 8'hff - r_pv[i].rec[REC_W-1:REC_W-DEPTH_W]};
            if (psc > pbsc) begin
                pbsc    = psc;
                pv_best = WAY_W'(i);
            end
        end
    end

    // row to write back
    t_ent_row new_ent;
    t_pv_row  new_pv;
    logic [WAY_W-1:0] wway;

    always_comb begin
        t_ent_way e;
        logic [FLAGS_W-1:0] f;
        new_ent = r_ent;
        new_pv  = r_pv;
        wway    = r_hit_any ? r_hit_way : r_best;
        e       = r_ent[wway];
        f       = e.flags;
        e.age   = r_age;
        if (!r_hit_any) begin
            e.tag = r_item.key[KEY_W-1:KEY_W-TAG_W];
        end
        case (r_item.cmd)
            CMD_LOWER, CMD_LOWER_ALL: begin
                e.ldep = r_item.search_depth;
                e.mv   = r_item.move_code;
                e.lval = r_item.score;
                if (r_hit_any) begin
                    f[FL_LOWER] = 1'b1;
                end else begin
                    e.udep = '0;
                    e.uval = '0;
                    f      = '0;
                    f[FL_LOWER] = 1'b1;
                end
                f[FL_ALL] = (r_item.cmd == CMD_LOWER_ALL);
            end
            CMD_UPPER, CMD_UPPER_CUT: begin
                e.udep = r_item.search_depth;
                e.uval = r_item.score;
                if (r_hit_any) begin
                    f[FL_UPPER] = 1'b1;
                end else begin
                    e.ldep = '0;
                    e.mv   = '0;
                    e.lval = '0;
                    f      = '0;
                    f[FL_UPPER] = 1'b1;
                end
                f[FL_CUT] = (r_item.cmd == CMD_UPPER_CUT);
            end
            default: begin
                e.ldep = r_item.search_depth;
                e.udep = r_item.search_depth;
                e.mv   = r_item.move_code;
                e.lval = r_item.score;
                e.uval = r_item.score;
                f      = r_item.exact_flags;
            end
        endcase
        e.flags = f;
        for (int i = 0; i < WAYS; i++) begin
            if (r_wipe[i]) begin
                new_ent[i]     = '0;
                new_ent[i].age = r_age ^ AGE_HALF;
            end
        end
        new_ent[wway] = e;
        new_pv[r_pv_hit ? r_pv_way : r_pv_best] =
            '{key: r_item.key,
              rec: {r_item.search_depth, r_item.score, r_item.move_code},
              age: r_age};
    end

    // clear sweep rows
    t_ent_row clr_ent;
    always_comb begin
        clr_ent = '0;
        for (int i = 0; i < WAYS; i++) begin
            clr_ent[i].age = AGE_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && ({1'b0, r_cnt} < (CW+1)'(EROWS))) begin
            ent_mem[r_cnt[ERA-1:0]] <= clr_ent;
        end else if (i_cmd.wr) begin
            ent_mem[erow] <= new_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && ({1'b0, r_cnt} < (CW+1)'(PROWS))) begin
            pv_mem[r_cnt[PRA-1:0]] <= '0;
        end else if (i_cmd.wr && (r_item.cmd == CMD_EXACT)) begin
            pv_mem[prow] <= new_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_ent <= ent_mem[erow];
            r_pv  <= pv_mem[prow];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_age <= r_age + 1'b1;
            end else if (i_cmd.clr_start) begin
                r_age <= '0;
            end
            if (i_cmd.clr_start) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item        <= i_item;
            r_res_matched <= 1'b0;
            r_res_way     <= '0;
        end
        if (i_cmd.score) begin
            r_hit_any <= hit_any;
            r_hit_way <= hit_way;
            r_wipe    <= wipe;
            r_best    <= best_way;
            r_pv_hit  <= pv_hit;
            r_pv_way  <= pv_hw;
            r_pv_best <= pv_best;
        end
        if (i_cmd.wr) begin
            r_res_matched <= r_hit_any;
            r_res_way     <= wway;
        end
        if (i_cmd.out_load) begin
            r_out <= '{matched: r_res_matched, way: r_res_way, done_res: 1'b1};
        end
    end

    assign o_sts.clr_last = (r_cnt == CW'(MROWS - 1));
    assign o_item         = r_out;

endmodule

// ----- rtl/core/four_way_bound_table_store_unit.sv -----
// Four-way bucketed search-result table with age/depth replacement.
// Input channel (i_in_valid / o_in_ready, i_in_item) carries one command per
// item: lower, lower_all, upper, upper_cut, exact stores, age tick or clear.
// Output channel (o_out_valid / i_out_ready, o_out_item) returns exactly one
// result item per command: matched flag, way written, done_res.
// Stores pass from accept to result: read the bucket row from the
// synchronous table memory, score the four ways, write the row back, load the
// output register. Age tick and unused codes go straight to the output load.
// Throughput is one item at a time; the next item is accepted once the result
// sits in the output register, even while the receiver stalls it.
// Clear sweeps one bucket row per cycle over max(TABLE_ENTRIES, PV_ENTRIES)/4
// rows, then answers. The same sweep runs after reset (16384 rows at default
// sizes), during which no item is accepted.
// The APB port holds index_bits at address 0 (reset 16); writes must only be
// made while the block is idle, which the block itself does not enforce.
module four_way_bound_table_store_unit import fwbt_pkg::*; #(
    parameter int TABLE_ENTRIES = 65536,
    parameter int PV_ENTRIES    = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    logic [IDX_W-1:0] r_index_bits;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-IDX_W){1'b0}}, r_index_bits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= IDX_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_index_bits <= pwdata[IDX_W-1:0];
        end
    end

    fwbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_item.cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    fwbt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PV_ENTRIES    (PV_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_item       (i_in_item),
        .i_index_bits (r_index_bits),
        .o_item       (o_out_item)
    );

    // one item in flight: ready drops right after an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.done_res)
        else $error("result without done_res");

    // a clear never leaves ready high during its sweep
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.clr_step && !dp_sts.clr_last) |-> !o_in_ready)
        else $error("ready during clear sweep");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import fwbt_pkg::*;

    localparam int          N_ENT          = 65536;
    localparam int          N_PV           = 65536;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam logic [2:0]  CMD_UNUSED     = 3'd7;
    localparam logic [2:0]  REG_INDEX_BITS = 3'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    four_way_bound_table_store_unit #(
        .TABLE_ENTRIES(N_ENT),
        .PV_ENTRIES   (N_PV)
    ) uut (.*);

    // predictor state
    t_ent_way    bound_tbl [N_ENT];
    t_pv_way     pv_tbl    [N_PV];
    logic [7:0]  cur_age;
    logic [4:0]  idx_bits;

    t_out_item   pending_results [$];
    int          n_errors;
    int          n_results;
    int          cycle_cnt;
    int          hold_len;
    bit          quiet;      // no idling on either side
    int          clears_left;
    logic [63:0] key_pool [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch #%0d %s: got %0h want %0h (t=%0t)", n_results, what, got, want,
                 $realtime);
        n_errors++;
    endtask

    function automatic void wipe_tables();
        for (int i = 0; i < N_ENT; i++) begin
            bound_tbl[i]     = '0;
            bound_tbl[i].age = AGE_HALF;
        end
        for (int i = 0; i < N_PV; i++)
            pv_tbl[i] = '0;
        cur_age = '0;
    endfunction

    function automatic logic [15:0] repl_rank(logic [7:0] age, logic [7:0] dep);
        logic [7:0] d;
        d = cur_age - age;
        return {d, 8'd255 - dep};
    endfunction

    function automatic t_out_item store_item(t_in_item it);
        t_out_item   r;
        logic [31:0] tg;
        logic [38:0] rec;
        int unsigned bits, base, a, w, best, s;
        logic [7:0]  md, dd;
        bit          hit, pv_done;
        r = '{matched: 1'b0, way: '0, done_res: 1'b1};
        tg = it.key[63:32];
        if (it.cmd == CMD_AGE_TICK) begin
            cur_age = cur_age + 8'd1;
            return r;
        end
        if (it.cmd == CMD_CLEAR) begin
            wipe_tables();
            return r;
        end
        if (it.cmd == CMD_UNUSED)
            return r;

        bits = (idx_bits < 2) ? 2 : ((idx_bits > 16) ? 16 : idx_bits);
        base = it.key[31:0] & ((32'd1 << bits) - 32'd4) & (N_ENT - 1);

        if (it.cmd == CMD_EXACT) begin
            rec = {it.search_depth, it.score, it.move_code};
            a = it.key[31:0] & (N_PV - 4);
            pv_done = 0;
            best = 0;
            w = 0;
            for (int i = 0; i < WAYS && !pv_done; i++) begin
                if (pv_tbl[a + i].key == it.key) begin
                    pv_tbl[a + i].rec = rec;
                    pv_tbl[a + i].age = cur_age;
                    pv_done = 1;
                end else begin
                    s = repl_rank(pv_tbl[a + i].age, pv_tbl[a + i].rec[38:31]);
                    if (s > best) begin
                        best = s;
                        w = i;
                    end
                end
            end
            if (!pv_done)
                pv_tbl[a + w] = '{key: it.key, rec: rec, age: cur_age};
        end

        best = 0;
        w = 0;
        for (int i = 0; i < WAYS; i++) begin
            a = (base + i) & (N_ENT - 1);
            md = (bound_tbl[a].ldep > bound_tbl[a].udep) ? bound_tbl[a].ldep
                                                         : bound_tbl[a].udep;
            hit = 0;
            if (bound_tbl[a].tag == tg) begin
                case (it.cmd)
                    CMD_LOWER:
                        hit = !bound_tbl[a].flags[FL_EXACT] &&
                              bound_tbl[a].ldep <= it.search_depth;
                    CMD_LOWER_ALL:
                        hit = (bound_tbl[a].ldep == 0 || bound_tbl[a].flags[FL_ALL]) &&
                              bound_tbl[a].ldep <= it.search_depth;
                    CMD_UPPER:
                        hit = !bound_tbl[a].flags[FL_EXACT] &&
                              bound_tbl[a].udep <= it.search_depth;
                    CMD_UPPER_CUT:
                        hit = (bound_tbl[a].udep == 0 || bound_tbl[a].flags[FL_CUT]) &&
                              bound_tbl[a].udep <= it.search_depth;
                    default:
                        hit = md <= it.search_depth;
                endcase
            end
            if (hit) begin
                bound_tbl[a].age = cur_age;
                if (it.cmd == CMD_LOWER || it.cmd == CMD_LOWER_ALL) begin
                    bound_tbl[a].ldep = it.search_depth;
                    bound_tbl[a].mv   = it.move_code;
                    bound_tbl[a].lval = it.score;
                    bound_tbl[a].flags[FL_LOWER] = 1'b1;
                    bound_tbl[a].flags[FL_ALL]   = (it.cmd == CMD_LOWER_ALL);
                end else if (it.cmd == CMD_UPPER || it.cmd == CMD_UPPER_CUT) begin
                    bound_tbl[a].udep = it.search_depth;
                    bound_tbl[a].uval = it.score;
                    bound_tbl[a].flags[FL_UPPER] = 1'b1;
                    bound_tbl[a].flags[FL_CUT]   = (it.cmd == CMD_UPPER_CUT);
                end else begin
                    bound_tbl[a].ldep  = it.search_depth;
                    bound_tbl[a].udep  = it.search_depth;
                    bound_tbl[a].mv    = it.move_code;
                    bound_tbl[a].lval  = it.score;
                    bound_tbl[a].uval  = it.score;
                    bound_tbl[a].flags = it.exact_flags;
                    // later ways holding the same position are dropped
                    for (int j = i + 1; j < WAYS; j++) begin
                        s = (base + j) & (N_ENT - 1);
                        dd = (bound_tbl[s].ldep > bound_tbl[s].udep) ? bound_tbl[s].ldep
                                                                     : bound_tbl[s].udep;
                        if (bound_tbl[s].tag == tg && dd <= it.search_depth) begin
                            bound_tbl[s]     = '0;
                            bound_tbl[s].age = cur_age ^ AGE_HALF;
                        end
                    end
                end
                r.matched = 1'b1;
                r.way     = WAY_W'(i);
                return r;
            end
            s = repl_rank(bound_tbl[a].age, md);
            if (s > best) begin
                best = s;
                w = i;
            end
        end

        a = (base + w) & (N_ENT - 1);
        bound_tbl[a].tag = tg;
        bound_tbl[a].age = cur_age;
        if (it.cmd == CMD_LOWER || it.cmd == CMD_LOWER_ALL) begin
            bound_tbl[a].udep  = '0;
            bound_tbl[a].uval  = '0;
            bound_tbl[a].ldep  = it.search_depth;
            bound_tbl[a].mv    = it.move_code;
            bound_tbl[a].lval  = it.score;
            bound_tbl[a].flags = '0;
            bound_tbl[a].flags[FL_LOWER] = 1'b1;
            bound_tbl[a].flags[FL_ALL]   = (it.cmd == CMD_LOWER_ALL);
        end else if (it.cmd == CMD_UPPER || it.cmd == CMD_UPPER_CUT) begin
            bound_tbl[a].ldep  = '0;
            bound_tbl[a].mv    = '0;
            bound_tbl[a].lval  = '0;
            bound_tbl[a].udep  = it.search_depth;
            bound_tbl[a].uval  = it.score;
            bound_tbl[a].flags = '0;
            bound_tbl[a].flags[FL_UPPER] = 1'b1;
            bound_tbl[a].flags[FL_CUT]   = (it.cmd == CMD_UPPER_CUT);
        end else begin
            bound_tbl[a].ldep  = it.search_depth;
            bound_tbl[a].udep  = it.search_depth;
            bound_tbl[a].mv    = it.move_code;
            bound_tbl[a].lval  = it.score;
            bound_tbl[a].uval  = it.score;
            bound_tbl[a].flags = it.exact_flags;
        end
        r.way = WAY_W'(w);
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(t_in_item it);
        while (!quiet && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(store_item(it));
        @(negedge i_clk);
    endtask

    task automatic send_cmd(logic [2:0] c, logic [63:0] k, logic [14:0] mv, logic [7:0] d,
                            logic [15:0] sc, logic [4:0] fl);
        t_in_item it;
        it = '{cmd: c, key: k, move_code: mv, search_depth: d, score: sc, exact_flags: fl};
        send_item(it);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_index_bits(logic [4:0] v);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_INDEX_BITS;
        pwdata  <= {27'd0, v};
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        idx_bits = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned r, p;
        it.move_code    = 15'($urandom());
        it.score        = 16'($urandom());
        it.exact_flags  = 5'($urandom());
        it.search_depth = ($urandom_range(9) < 7) ? 8'($urandom_range(15))
                                                  : 8'($urandom_range(255));
        r = $urandom_range(999);
        if (r < 40)
            it.cmd = CMD_AGE_TICK;
        else if (r < 48)
            it.cmd = CMD_UNUSED;
        else if (r < 51 && clears_left > 0) begin
            it.cmd = CMD_CLEAR;
            clears_left--;
        end else
            it.cmd = 3'($urandom_range(4));
        // mostly reuse a few positions so that buckets fill and tags collide
        p = $urandom_range(7);
        r = $urandom_range(9);
        if (r < 2)
            key_pool[p] = {$urandom(), $urandom()};
        else if (r < 3)
            key_pool[p] = {32'd0, key_pool[p][31:0]};
        else if (r < 4)
            key_pool[p][1:0] = 2'($urandom());
        it.key = key_pool[p];
        return it;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_item(random_item());
    endtask

    // result side: ready pattern driven at the falling edge
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_out_ready <= 1'b0;
                hold_len--;
            end else
                i_out_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_out_item want;
            if (pending_results.size() == 0) begin
                report("unexpected result", 32'(o_out_item), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.matched !== want.matched)
                    report("matched", 32'(o_out_item.matched), 32'(want.matched));
                if (o_out_item.way !== want.way)
                    report("way", 32'(o_out_item.way), 32'(want.way));
                if (o_out_item.done_res !== want.done_res)
                    report("done_res", 32'(o_out_item.done_res), 32'(want.done_res));
            end
            n_results++;
        end
    end

    task automatic test_directed();
        logic [63:0] k;
        k = 64'h1234_5678_0000_0104;
        // empty ways carry tag 0, so a zero key hits way 0
        send_cmd(CMD_LOWER, 64'd0, 15'h7fff, 8'd0, 16'h8000, 5'd0);
        send_cmd(CMD_UPPER, 64'd0, 15'd0, 8'd255, 16'h7fff, 5'd31);
        send_cmd(CMD_LOWER_ALL, '1, 15'h7fff, 8'd255, 16'h7fff, 5'd31);
        send_cmd(CMD_UPPER_CUT, '1, 15'd0, 8'd0, 16'h8000, 5'd0);
        send_cmd(CMD_UPPER_CUT, '1, 15'd1, 8'd3, 16'h0001, 5'd0);
        send_cmd(CMD_EXACT, '1, 15'h7fff, 8'd255, 16'hffff, 5'd31);
        send_cmd(CMD_EXACT, '1, 15'h1234, 8'd255, 16'h0000, 5'd0);
        // exact way blocks a plain lower store, second way gets the same tag
        send_cmd(CMD_EXACT, k, 15'h0100, 8'd4, 16'h0010, 5'd16);
        send_cmd(CMD_LOWER, k, 15'h0200, 8'd6, 16'h0020, 5'd0);
        send_cmd(CMD_UPPER, k, 15'h0000, 8'd6, 16'hfff0, 5'd0);
        send_cmd(CMD_LOWER_ALL, k, 15'h0300, 8'd2, 16'h0030, 5'd0);
        send_cmd(CMD_EXACT, k, 15'h0400, 8'd9, 16'h0040, 5'd16);
        send_cmd(CMD_LOWER, k, 15'h0500, 8'd1, 16'h0050, 5'd0);
        send_cmd(CMD_AGE_TICK, '0, '0, '0, '0, '0);
        send_cmd(CMD_LOWER, k + 64'h1_0000_0000, 15'h0600, 8'd0, 16'h0060, 5'd0);
        send_cmd(CMD_AGE_TICK, '1, '1, '1, '1, '1);
        send_cmd(CMD_UPPER, k + 64'h2_0000_0000, 15'h0, 8'd200, 16'h0070, 5'd0);
        send_cmd(CMD_UNUSED, k, 15'h7fff, 8'd7, 16'h1111, 5'd7);
        send_cmd(CMD_LOWER, k + 64'h3_0000_0000, 15'h0700, 8'd1, 16'h0080, 5'd0);
        send_cmd(CMD_CLEAR, '0, '0, '0, '0, '0);
        send_cmd(CMD_EXACT, k, 15'h0800, 8'd0, 16'h0090, 5'd1);
        send_cmd(CMD_UPPER_CUT, 64'd0, 15'h0, 8'd0, 16'h00a0, 5'd0);
    endtask

    task automatic test_index_bits();
        // both extremes, the clamped codes and a middle value
        logic [4:0] vals [6] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd7, 5'd1};
        foreach (vals[i]) begin
            write_index_bits(vals[i]);
            run_random(70);
        end
        write_index_bits(5'($urandom_range(2, 12)));
        run_random(60);
    endtask

    task automatic test_output_stall();
        wait_idle();
        hold_len = 120;
        repeat (12) send_item(random_item());
    endtask

    task automatic test_random_traffic();
        write_index_bits(5'd4);
        run_random(350);
        quiet = 1;
        run_random(200);
        quiet = 0;
        write_index_bits(5'd16);
        run_random(250);
    endtask

    initial begin
        cycle_cnt   = 0;
        n_errors    = 0;
        n_results   = 0;
        hold_len    = 0;
        quiet       = 0;
        clears_left = 2;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        foreach (key_pool[i])
            key_pool[i] = {$urandom_range(3), $urandom()};
        wipe_tables();
        idx_bits = IDX_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the block sweeps its tables after reset before taking items
        @(negedge i_clk);
        while (!o_in_ready)
            @(negedge i_clk);

        test_directed();
        test_index_bits();
        test_output_stall();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (n_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/fwbt_pkg.sv
rtl/core/fwbt_ctrl.sv
rtl/core/fwbt_datapath.sv
rtl/core/four_way_bound_table_store_unit.sv
verif/tb_top.sv
